// ===== rtl/tgi_pkg.sv =====
// ============================================================================
// tgi_pkg: shared types for the trilinear grid interpolator
// Controller states, command and status bundles, register indexes.
// ============================================================================
`default_nettype none
package tgi_pkg;
   localparam int unsigned AddrWidth = 15;
   localparam int unsigned Depth     = 32768;
   localparam int unsigned NumQty    = 6;

   typedef enum logic [2:0] {
      CSR_X_ORG = 3'd0, CSR_Y_ORG = 3'd1, CSR_Z_ORG = 3'd2,
      CSR_X_INV = 3'd3, CSR_Y_INV = 3'd4, CSR_Z_INV = 3'd5
   } csr_index_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MAP  = 7'b0000010,
      ST_CHK  = 7'b0000100,
      ST_READ = 7'b0001000,
      ST_ZLRP = 7'b0010000,
      ST_YXLR = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic       capture;   // latch request
      logic       write;     // store load cell
      logic       map;       // run axis products
      logic       check;     // compute range and base address
      logic       rd_en;     // issue corner read
      logic [2:0] corner;    // corner being read
      logic       lerp_z;    // capture one z blend
      logic [1:0] zsel;      // which z pair
      logic       lerp_y;    // y blend stage
      logic       rsp_load;  // load result register
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic in_range;
   } status_type;
endpackage
`default_nettype wire

// ===== rtl/tgi_datapath.sv =====
// ============================================================================
// tgi_datapath: grid memories, axis mapping and blend arithmetic
// Six quantity memories, three axis multipliers, blend arithmetic for each
// quantity at the z, y and x stages, and the result register.
// ============================================================================
`default_nettype none
module tgi_datapath import tgi_pkg::*; #(
   parameter int unsigned GRID_X = 32,
   parameter int unsigned GRID_Y = 32,
   parameter int unsigned GRID_Z = 32
) (
   input  wire logic               clock,
   input  wire cmd_type            cmd,
   output status_type              status,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_write_data,
   input  wire logic               reset,
   input  wire logic               req_type,
   input  wire logic [14:0]        req_cell_index,
   input  wire logic signed [31:0] req_energy_in,
   input  wire logic signed [31:0] req_baryon_in,
   input  wire logic signed [31:0] req_charge_in,
   input  wire logic signed [31:0] req_velx_in,
   input  wire logic signed [31:0] req_vely_in,
   input  wire logic signed [31:0] req_velz_in,
   input  wire logic signed [31:0] req_x_pos,
   input  wire logic signed [31:0] req_y_pos,
   input  wire logic signed [31:0] req_eta_pos,
   output logic signed [31:0]      rsp_energy_out,
   output logic signed [31:0]      rsp_baryon_out,
   output logic signed [31:0]      rsp_charge_out,
   output logic signed [31:0]      rsp_velx_out,
   output logic signed [31:0]      rsp_vely_out,
   output logic signed [31:0]      rsp_velz_out,
   output logic                    rsp_in_range
);
   // configuration registers
   logic [31:0] org_ff [3];
   logic [31:0] inv_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            org_ff[i] <= 32'd0;
            inv_ff[i] <= 32'd65536;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_X_ORG: org_ff[0] <= csr_write_data;
            CSR_Y_ORG: org_ff[1] <= csr_write_data;
            CSR_Z_ORG: org_ff[2] <= csr_write_data;
            CSR_X_INV: inv_ff[0] <= csr_write_data;
            CSR_Y_INV: inv_ff[1] <= csr_write_data;
            CSR_Z_INV: inv_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // captured request
   logic        type_ff;
   logic [14:0] addr_ff;
   logic [31:0] val_ff [NumQty];
   logic [31:0] pos_ff [3];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff   <= req_type;
         addr_ff   <= req_cell_index;
         val_ff[0] <= req_energy_in;
         val_ff[1] <= req_baryon_in;
         val_ff[2] <= req_charge_in;
         val_ff[3] <= req_velx_in;
         val_ff[4] <= req_vely_in;
         val_ff[5] <= req_velz_in;
         pos_ff[0] <= req_x_pos;
         pos_ff[1] <= req_y_pos;
         pos_ff[2] <= req_eta_pos;
      end
   end

   // axis products: 33-bit magnitude split as 32x32 plus top-bit term
   logic [63:0] prod_ff [3];
   logic [32:0] mag_top_ff;
   logic [2:0]  neg_ff;
   logic [2:0]  top_ff;

   always_ff @(posedge clock) begin
      if (cmd.map) begin
         for (int i = 0; i < 3; i++) begin
            logic signed [32:0] d;
            logic [32:0]        mag;
            d         = $signed({pos_ff[i][31], pos_ff[i]})
                      - $signed({org_ff[i][31], org_ff[i]});
            mag       = d[32] ? 33'(-d) : 33'(d);
            neg_ff[i] <= d[32];
            top_ff[i] <= mag[32];
            prod_ff[i] <= 64'(mag[31:0]) * 64'(inv_ff[i]);
         end
      end
   end

   // range check and base address
   localparam int unsigned SIZES [3] = '{GRID_X, GRID_Y, GRID_Z};
   logic [15:0]          frac_ff [3];
   logic                 ok_ff;
   logic [AddrWidth-1:0] base_ff;

   always_comb begin
      status.is_query = type_ff;
      status.in_range = ok_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         logic        ok;
         logic [33:0] hi [3];
         logic [31:0] lin;
         ok = 1'b1;
         for (int i = 0; i < 3; i++) begin
            // magnitude bit 32 adds inv_step at bit 32 of the product
            hi[i] = 34'(prod_ff[i][63:32]) + (top_ff[i] ? 34'(inv_ff[i]) : 34'd0);
            if (neg_ff[i] && (prod_ff[i] != 64'd0 || (top_ff[i] && inv_ff[i] != 32'd0)))
               ok = 1'b0;
            if (hi[i] > 34'(SIZES[i] - 2)) ok = 1'b0;
            frac_ff[i] <= prod_ff[i][31:16];
         end
         lin = (hi[0][7:0] * 32'(GRID_Y) + 32'(hi[1][7:0])) * 32'(GRID_Z)
               + 32'(hi[2][7:0]);
         ok_ff   <= ok;
         base_ff <= lin[AddrWidth-1:0];
      end
   end

   // corner address: corner bits {jx,jy,jz}
   logic [AddrWidth-1:0] rd_addr;
   always_comb begin
      logic [31:0] off;
      off = (cmd.corner[2] ? 32'(GRID_Y * GRID_Z) : 32'd0)
          + (cmd.corner[1] ? 32'(GRID_Z) : 32'd0)
          + (cmd.corner[0] ? 32'd1 : 32'd0);
      rd_addr = base_ff + off[AddrWidth-1:0];
   end

   // memories
   logic [31:0] rd_ff [NumQty];
   for (genvar q = 0; q < NumQty; q++) begin : g_mem
      logic [31:0] mem [Depth];
      always_ff @(posedge clock) begin
         if (cmd.write) mem[addr_ff] <= val_ff[q];
         if (cmd.rd_en) rd_ff[q] <= mem[rd_addr];
      end
   end

   // blend: floor((a*(65536-f)+b*f+32768)/65536) = a + floor((b-a)*f+32768 >> 16)
   function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic [15:0] f);
      logic signed [32:0] diff;
      logic signed [50:0] acc;
      diff = 33'(b) - 33'(a);
      acc  = 51'(diff) * $signed({35'd0, f}) + 51'sd32768;
      return 32'(51'(a) + (acc >>> 16));
   endfunction

   // z stage: pair up corners as they return
   logic signed [31:0] lo_ff [NumQty];
   logic signed [31:0] z_ff  [NumQty][4];
   logic signed [31:0] y_ff  [NumQty][2];
   logic               half_ff;

   always_ff @(posedge clock) begin
      if (cmd.lerp_z) begin
         for (int q = 0; q < NumQty; q++) begin
            if (!half_ff) lo_ff[q] <= rd_ff[q];
            else z_ff[q][cmd.zsel] <= lerp(lo_ff[q], rd_ff[q], frac_ff[2]);
         end
         half_ff <= !half_ff;
      end
      if (cmd.capture) half_ff <= 1'b0;
      if (cmd.lerp_y) begin
         for (int q = 0; q < NumQty; q++) begin
            y_ff[q][0] <= lerp(z_ff[q][0], z_ff[q][1], frac_ff[1]);
            y_ff[q][1] <= lerp(z_ff[q][2], z_ff[q][3], frac_ff[1]);
         end
      end
   end

   // x stage into result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         logic signed [31:0] r [NumQty];
         for (int q = 0; q < NumQty; q++)
            r[q] = ok_ff ? lerp(y_ff[q][0], y_ff[q][1], frac_ff[0]) : 32'sd0;
         rsp_energy_out <= r[0];
         rsp_baryon_out <= r[1];
         rsp_charge_out <= r[2];
         rsp_velx_out   <= r[3];
         rsp_vely_out   <= r[4];
         rsp_velz_out   <= r[5];
         rsp_in_range   <= ok_ff;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/tgi_controller.sv =====
// ============================================================================
// tgi_controller: sequencer for loads and queries
// Steps each request through mapping, corner reads and blending.
// ============================================================================
`default_nettype none
module tgi_controller import tgi_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);
   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       rv_ff, rv_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rv_in    = rv_ff && !rsp_ready;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MAP;
            end
         end
         ST_MAP: begin
            if (!status.is_query) begin
               cmd.write = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd.map  = 1'b1;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            cmd.check = 1'b1;
            cnt_in    = 4'd0;
            state_in  = ST_READ;
         end
         ST_READ: begin
            // reads issue for counts 0..7, each blend follows in the cycle after its read
            if (cnt_ff < 4'd8) begin
               cmd.rd_en  = 1'b1;
               cmd.corner = cnt_ff[2:0];
            end
            if (cnt_ff != 4'd0) begin
               cmd.lerp_z = 1'b1;
               cmd.zsel   = 2'(({1'b0, cnt_ff} - 5'd1) >> 1);
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd8) state_in = ST_ZLRP;
         end
         ST_ZLRP: begin
            cmd.lerp_y = 1'b1;
            state_in   = ST_YXLR;
         end
         ST_YXLR: begin
            if (!rv_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rv_in        = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 4'd0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/trilinear_grid_interpolator.sv =====
// ============================================================================
// trilinear_grid_interpolator: six-quantity 3D grid with trilinear lookup
// Top level joining the sequencer and the datapath.
// ============================================================================
// Usage: a request with req_type 0 stores six values at req_cell_index and
// returns no response; it is captured, then written. A request with
// req_type 1 maps (x, y, eta) onto the grid and returns one response with
// the six blended values and rsp_in_range. From acceptance to rsp_valid a
// query passes through the multiply, the range check, the corner reads, in
// which the eight corner cells are read one per cycle from the single read
// port of each quantity memory, and then the y and x blends.
// One request is in flight at a time; req_ready is high only while idle,
// so a new query is accepted only once the previous one has finished.
// The response sits in an output register, so a stalled receiver does not
// block the next request until its response is ready to load.
// Reset clears the sequencer and sets origins to 0 and inverse steps to
// 1.0; grid memories are not cleared and must be loaded before queries.
// Registers csr_index 0..5: x, y, eta origin, then x, y, eta inverse step.
// ============================================================================
`default_nettype none
module trilinear_grid_interpolator import tgi_pkg::*; #(
   parameter int unsigned GRID_X = 32,
   parameter int unsigned GRID_Y = 32,
   parameter int unsigned GRID_Z = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_write_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_type,
   input  wire logic [14:0]        req_cell_index,
   input  wire logic signed [31:0] req_energy_in,
   input  wire logic signed [31:0] req_baryon_in,
   input  wire logic signed [31:0] req_charge_in,
   input  wire logic signed [31:0] req_velx_in,
   input  wire logic signed [31:0] req_vely_in,
   input  wire logic signed [31:0] req_velz_in,
   input  wire logic signed [31:0] req_x_pos,
   input  wire logic signed [31:0] req_y_pos,
   input  wire logic signed [31:0] req_eta_pos,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_energy_out,
   output logic signed [31:0]      rsp_baryon_out,
   output logic signed [31:0]      rsp_charge_out,
   output logic signed [31:0]      rsp_velx_out,
   output logic signed [31:0]      rsp_vely_out,
   output logic signed [31:0]      rsp_velz_out,
   output logic                    rsp_in_range
);
   cmd_type    cmd;
   status_type status;

   tgi_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   tgi_datapath #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_dp (
      .clock, .cmd, .status, .csr_write_enable, .csr_index, .csr_write_data,
      .reset, .req_type, .req_cell_index, .req_energy_in, .req_baryon_in,
      .req_charge_in, .req_velx_in, .req_vely_in, .req_velz_in, .req_x_pos,
      .req_y_pos, .req_eta_pos, .rsp_energy_out, .rsp_baryon_out,
      .rsp_charge_out, .rsp_velx_out, .rsp_vely_out, .rsp_velz_out,
      .rsp_in_range
   );

   // out-of-range response carries zero values
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_range) |-> (rsp_energy_out == 0 && rsp_velz_out == 0))
      else $error("out-of-range response not zero");

   // no request taken while a query is in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // a held response stays valid and keeps its energy value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_energy_out)))
      else $error("stalled response changed");
endmodule
`default_nettype wire
